[hw/rtl/bmss_pkg.sv]
// Shared types and constants for the Boyer-Moore bad-character search block.
// No dependencies; used by every module in hw/rtl.
package bmss_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int TEXT_MAX_DEF    = 64;
	localparam int BYTE_W          = 8;
	localparam int POS_W           = 6;
	localparam int ALPHABET        = 256;
	localparam int ALPHA_W         = 8;
	// table entry holds a pattern index, at most 63
	localparam int OCC_W           = 6;
	// search offset and shift arithmetic; offset + shift stays below 256
	localparam int SEARCH_W        = 8;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_text;
	} item_t;

	typedef struct packed {
		logic             match_found;
		logic [POS_W-1:0] position;
		logic             final_item;
	} result_t;

	localparam logic KIND_PATTERN = 1'b0;
	localparam logic KIND_TEXT    = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_BUILD_RD,
		ST_BUILD_WR,
		ST_CMP_RD,
		ST_CMP,
		ST_MATCH,
		ST_OCC_RD,
		ST_SHIFT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               clear;
		logic               wr_en;
		logic [ALPHA_W-1:0] wr_addr;
		logic [OCC_W-1:0]   wr_data;
		logic [ALPHA_W-1:0] rd_addr;
	} occ_ctl_t;

	typedef struct packed {
		logic             hit;
		logic [OCC_W-1:0] idx;
	} occ_rd_t;

endpackage

[hw/rtl/bmss_store.sv]
// Byte store: one write port, one read port with registered read data.
// Depends on bmss_pkg for the byte width.
module bmss_store #(
	parameter int DEPTH = bmss_pkg::PATTERN_MAX_DEF,
	parameter int AW    = 4
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [bmss_pkg::BYTE_W-1:0] wr_data,
	input  logic [AW-1:0]               rd_addr,
	output logic [bmss_pkg::BYTE_W-1:0] rd_data
);

	logic [bmss_pkg::BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

[hw/rtl/bmss_occ_table.sv]
// Last-occurrence table: 256 entries of pattern index, one valid bit per entry.
// A missing entry reads as no occurrence. Depends on bmss_pkg.
module bmss_occ_table (
	input  logic               clk,
	input  logic               arst_n,
	input  bmss_pkg::occ_ctl_t ctl,
	output bmss_pkg::occ_rd_t  rd
);

	logic [bmss_pkg::OCC_W-1:0]    mem [bmss_pkg::ALPHABET];
	logic [bmss_pkg::ALPHABET-1:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clear) begin
			valid_q <= '0;
		end else if (ctl.wr_en) begin
			valid_q[ctl.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= ctl.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd.hit <= valid_q[ctl.rd_addr];
		rd.idx <= mem[ctl.rd_addr];
	end

endmodule

[hw/rtl/boyer_moore_string_search.sv]
// Top level of the Boyer-Moore bad-character search: sequencer, shift unit,
// output register. Depends on bmss_pkg, bmss_store and bmss_occ_table.
//
// Usage:
//   item channel: each word appends one byte. kind 0 appends to the pattern,
//   kind 1 to the text. Bytes past PATTERN_MAX / TEXT_MAX are dropped. A text
//   word with end_of_text set starts the search; item_ready stays low until the
//   last result of the search is in the output register.
//   result channel: one word per match start, ascending, final_item set on the
//   last one. No match, empty pattern or pattern longer than text gives one
//   word with match_found 0, position 0, final_item 1.
// Sequence:
//   loading takes one word per cycle while item_ready is high. A search
//   runs ST_START, ST_BUILD_RD and ST_BUILD_WR per pattern byte for the table,
//   then per alignment ST_CMP_RD and ST_CMP per compared byte, then ST_SHIFT
//   after a mismatch, or ST_MATCH, ST_OCC_RD, ST_SHIFT after a match (ST_MATCH
//   alone when it ends at the end of the text). The single compare/shift unit
//   and one read port per store set this order. ST_DONE loads the last result.
//   Results go through a one-word output register; a stalled receiver only
//   holds up the sequencer when a second result is ready to go.
// Reset: lengths clear, table entries read as no occurrence, no result
//   pending. Store contents are not cleared. Both lengths clear after each
//   search.
module boyer_moore_string_search #(
	parameter int PATTERN_MAX = bmss_pkg::PATTERN_MAX_DEF,
	parameter int TEXT_MAX    = bmss_pkg::TEXT_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  bmss_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output bmss_pkg::result_t result
);

	localparam int PAW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int TAW = $clog2(TEXT_MAX);
	localparam int PLW = $clog2(PATTERN_MAX + 1);
	localparam int TLW = $clog2(TEXT_MAX + 1);
	localparam int SW  = bmss_pkg::SEARCH_W;

	bmss_pkg::state_t state_q, state_d;

	logic [PLW-1:0] plen_q, plen_d;  // pattern length
	logic [TLW-1:0] tlen_q, tlen_d;  // text length
	logic [PLW-1:0] i_q, i_d;        // table build index
	logic [PAW-1:0] j_q, j_d;        // compare index, walks right to left
	logic [SW-1:0]  s_q, s_d;        // alignment offset in the text
	logic [SW-1:0]  base_q, base_d;  // j on a mismatch, m after a match
	logic           pend_valid_q, pend_valid_d;
	logic [bmss_pkg::POS_W-1:0] pend_pos_q, pend_pos_d;

	logic              res_valid_q;
	bmss_pkg::result_t res_q;
	logic              out_load;
	bmss_pkg::result_t out_word;
	logic              slot_free;

	logic                        accept;
	logic                        pat_we, txt_we;
	logic [PAW-1:0]              pat_raddr;
	logic [TAW-1:0]              txt_raddr;
	logic [bmss_pkg::BYTE_W-1:0] pat_rdata, txt_rdata;

	bmss_pkg::occ_ctl_t occ_ctl;
	bmss_pkg::occ_rd_t  occ_rd;

	logic [SW-1:0]   m_ext, n_ext, lim, s_plus_j, s_plus_m, s_step, s_inc;
	logic signed [SW:0] last9, diff9;

	// ------------------------------------------------------------------
	// Stores
	// ------------------------------------------------------------------
	bmss_store #(.DEPTH(PATTERN_MAX), .AW(PAW)) u_pat (
		.clk    (clk),
		.wr_en  (pat_we),
		.wr_addr(plen_q[PAW-1:0]),
		.wr_data(item.data_byte),
		.rd_addr(pat_raddr),
		.rd_data(pat_rdata)
	);

	bmss_store #(.DEPTH(TEXT_MAX), .AW(TAW)) u_txt (
		.clk    (clk),
		.wr_en  (txt_we),
		.wr_addr(tlen_q[TAW-1:0]),
		.wr_data(item.data_byte),
		.rd_addr(txt_raddr),
		.rd_data(txt_rdata)
	);

	bmss_occ_table u_occ (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (occ_ctl),
		.rd    (occ_rd)
	);

	// ------------------------------------------------------------------
	// Shared arithmetic
	// ------------------------------------------------------------------
	assign m_ext    = SW'(plen_q);
	assign n_ext    = SW'(tlen_q);
	assign lim      = n_ext - m_ext;            // last legal alignment
	assign s_plus_j = s_q + SW'(j_q);
	assign s_plus_m = s_q + m_ext;
	assign s_inc    = s_q + SW'(1);

	// bad-character shift: base - last, at least 1; absent byte counts as -1
	assign last9 = occ_rd.hit ? $signed({1'b0, SW'(occ_rd.idx)}) : '1;
	assign diff9 = $signed({1'b0, base_q}) - last9;
	assign s_step = s_q + ((diff9 > $signed((SW+1)'(1))) ? diff9[SW-1:0] : SW'(1));

	assign slot_free  = !res_valid_q || result_ready;
	assign item_ready = (state_q == bmss_pkg::ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign pat_we     = accept && (item.kind == bmss_pkg::KIND_PATTERN) &&
	                    (plen_q < PLW'(PATTERN_MAX));
	assign txt_we     = accept && (item.kind == bmss_pkg::KIND_TEXT) &&
	                    (tlen_q < TLW'(TEXT_MAX));

	assign pat_raddr = (state_q == bmss_pkg::ST_BUILD_RD) ? i_q[PAW-1:0] : j_q;
	assign txt_raddr = (state_q == bmss_pkg::ST_MATCH) ? s_plus_m[TAW-1:0]
	                                                   : s_plus_j[TAW-1:0];

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bmss_pkg::ST_IDLE;
			plen_q       <= '0;
			tlen_q       <= '0;
			i_q          <= '0;
			j_q          <= '0;
			s_q          <= '0;
			base_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_pos_q   <= '0;
		end else begin
			state_q      <= state_d;
			plen_q       <= plen_d;
			tlen_q       <= tlen_d;
			i_q          <= i_d;
			j_q          <= j_d;
			s_q          <= s_d;
			base_q       <= base_d;
			pend_valid_q <= pend_valid_d;
			pend_pos_q   <= pend_pos_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		plen_d       = plen_q;
		tlen_d       = tlen_q;
		i_d          = i_q;
		j_d          = j_q;
		s_d          = s_q;
		base_d       = base_q;
		pend_valid_d = pend_valid_q;
		pend_pos_d   = pend_pos_q;
		out_load     = 1'b0;
		out_word     = '0;
		occ_ctl      = '0;
		occ_ctl.rd_addr = txt_rdata;
		occ_ctl.wr_addr = pat_rdata;
		occ_ctl.wr_data = bmss_pkg::OCC_W'(i_q);

		case (state_q)
			bmss_pkg::ST_IDLE: begin
				if (pat_we) begin
					plen_d = plen_q + PLW'(1);
				end
				if (txt_we) begin
					tlen_d = tlen_q + TLW'(1);
				end
				if (accept && item.kind == bmss_pkg::KIND_TEXT && item.end_of_text) begin
					state_d = bmss_pkg::ST_START;
				end
			end
			bmss_pkg::ST_START: begin
				occ_ctl.clear = 1'b1;
				pend_valid_d  = 1'b0;
				i_d           = '0;
				s_d           = '0;
				if (plen_q == '0 || m_ext > n_ext) begin
					state_d = bmss_pkg::ST_DONE;
				end else begin
					state_d = bmss_pkg::ST_BUILD_RD;
				end
			end
			bmss_pkg::ST_BUILD_RD: begin
				state_d = bmss_pkg::ST_BUILD_WR;
			end
			bmss_pkg::ST_BUILD_WR: begin
				occ_ctl.wr_en = 1'b1;
				i_d = i_q + PLW'(1);
				if (i_d == plen_q) begin
					j_d     = PAW'(plen_q - PLW'(1));
					state_d = bmss_pkg::ST_CMP_RD;
				end else begin
					state_d = bmss_pkg::ST_BUILD_RD;
				end
			end
			bmss_pkg::ST_CMP_RD: begin
				state_d = bmss_pkg::ST_CMP;
			end
			bmss_pkg::ST_CMP: begin
				if (pat_rdata == txt_rdata) begin
					if (j_q == '0) begin
						state_d = bmss_pkg::ST_MATCH;
					end else begin
						j_d     = j_q - PAW'(1);
						state_d = bmss_pkg::ST_CMP_RD;
					end
				end else begin
					// table read at the mismatched text byte is in flight
					base_d  = SW'(j_q);
					state_d = bmss_pkg::ST_SHIFT;
				end
			end
			bmss_pkg::ST_MATCH: begin
				// earlier match goes out now, this one waits to learn if it is last
				if (!pend_valid_q || slot_free) begin
					if (pend_valid_q) begin
						out_load             = 1'b1;
						out_word.match_found = 1'b1;
						out_word.position    = pend_pos_q;
						out_word.final_item  = 1'b0;
					end
					pend_valid_d = 1'b1;
					pend_pos_d   = s_q[bmss_pkg::POS_W-1:0];
					if (s_plus_m < n_ext) begin
						state_d = bmss_pkg::ST_OCC_RD;
					end else begin
						s_d = s_inc;
						if (s_inc > lim) begin
							state_d = bmss_pkg::ST_DONE;
						end else begin
							j_d     = PAW'(plen_q - PLW'(1));
							state_d = bmss_pkg::ST_CMP_RD;
						end
					end
				end
			end
			bmss_pkg::ST_OCC_RD: begin
				base_d  = m_ext;
				state_d = bmss_pkg::ST_SHIFT;
			end
			bmss_pkg::ST_SHIFT: begin
				s_d = s_step;
				if (s_step > lim) begin
					state_d = bmss_pkg::ST_DONE;
				end else begin
					j_d     = PAW'(plen_q - PLW'(1));
					state_d = bmss_pkg::ST_CMP_RD;
				end
			end
			bmss_pkg::ST_DONE: begin
				if (slot_free) begin
					out_load             = 1'b1;
					out_word.match_found = pend_valid_q;
					out_word.position    = pend_valid_q ? pend_pos_q : '0;
					out_word.final_item  = 1'b1;
					pend_valid_d         = 1'b0;
					plen_d               = '0;
					tlen_d               = '0;
					state_d              = bmss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bmss_pkg::ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= out_word;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_cmp_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bmss_pkg::ST_CMP_RD) |-> (s_plus_j < n_ext))
		else $error("compare address beyond stored text");

	a_notfound_final: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.match_found) |-> result.final_item)
		else $error("not-found word without final_item");

	a_shift_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bmss_pkg::ST_SHIFT) |=> (s_q > $past(s_q)))
		else $error("search offset did not advance");

	a_lengths_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bmss_pkg::ST_DONE && slot_free) |=> (plen_q == '0 && tlen_q == '0))
		else $error("lengths not cleared after search");

endmodule

[sim/tb_boyer_moore_string_search.sv]
// Self-checking testbench for the Boyer-Moore bad-character search block.
// Depends on bmss_pkg and boyer_moore_string_search; predicts match words in-line.
module tb_boyer_moore_string_search;
	timeunit 1ns;
	timeprecision 1ps;

	import bmss_pkg::*;

	localparam int PAT_DEPTH  = PATTERN_MAX_DEF;
	localparam int TXT_DEPTH  = TEXT_MAX_DEF;
	// No handshake on either channel for this long means the block is hung.
	localparam int HANG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 100;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	boyer_moore_string_search u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Words waiting to be driven, and match words the block still owes us.
	item_t   word_q[$];
	result_t match_exp[$];

	int words_queued = 0;
	int words_taken  = 0;
	int err_count    = 0;
	int idle_cycles  = 0;

	// Idle odds in percent, changed by the stimulus thread between phases.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// Handshake seen at the last rising edge; the driver uses it at the falling edge.
	bit item_took = 1'b0;
	bit res_took  = 1'b0;

	// Our own copy of the block's stores and lengths.
	logic [BYTE_W-1:0] pat_mem [PAT_DEPTH];
	logic [BYTE_W-1:0] txt_mem [TXT_DEPTH];
	int pat_cnt = 0;
	int txt_cnt = 0;

	task automatic report_mismatch(string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		err_count++;
	endtask

	// Bad-character-only search over the stored bytes, right-to-left compare.
	// Queues one word per match start (ascending), final_item on the last; a
	// lone not-found word when there is nothing to report. Lengths clear after.
	function automatic void run_bad_char_search();
		int      last_pos [ALPHABET];
		int      m;
		int      n;
		int      s;
		int      j;
		int      shift;
		bit      have;
		result_t r;

		m = pat_cnt;
		n = txt_cnt;
		s = 0;
		have = 1'b0;
		r = '0;
		for (int i = 0; i < ALPHABET; i++)
			last_pos[i] = -1;
		if (m > 0 && m <= n) begin
			for (int i = 0; i < m; i++)
				last_pos[pat_mem[i]] = i;
			while (s <= n - m) begin
				j = m - 1;
				while (j >= 0 && pat_mem[j] == txt_mem[s + j])
					j--;
				if (j < 0) begin
					// hold back one word so the last can carry final_item
					if (have)
						match_exp.insert(match_exp.size(), r);
					r = '{match_found: 1'b1, position: POS_W'(s), final_item: 1'b0};
					have = 1'b1;
					if (s + m < n)
						s += m - last_pos[txt_mem[s + m]];
					else
						s += 1;
				end else begin
					shift = j - last_pos[txt_mem[s + j]];
					s += (shift > 1) ? shift : 1;
				end
			end
		end
		if (!have)
			r = '0;
		r.final_item = 1'b1;
		match_exp.insert(match_exp.size(), r);
		pat_cnt = 0;
		txt_cnt = 0;
	endfunction

	// Apply one accepted word to the predictor. Bytes past a full store drop,
	// end_of_text on a pattern word is ignored.
	function automatic void absorb_word(item_t w);
		if (w.kind == KIND_PATTERN) begin
			if (pat_cnt < PAT_DEPTH) begin
				pat_mem[pat_cnt] = w.data_byte;
				pat_cnt++;
			end
		end else begin
			if (txt_cnt < TXT_DEPTH) begin
				txt_mem[txt_cnt] = w.data_byte;
				txt_cnt++;
			end
			if (w.end_of_text)
				run_bad_char_search();
		end
	endfunction

	task automatic check_result(result_t got);
		result_t want;
		if (match_exp.size() == 0) begin
			report_mismatch($sformatf("result with nothing expected: found=%0b pos=%0d final=%0b",
				got.match_found, got.position, got.final_item));
			return;
		end
		want = match_exp.pop_front();
		if (got.match_found !== want.match_found)
			report_mismatch($sformatf("match_found %0b, expected %0b",
				got.match_found, want.match_found));
		if (got.position !== want.position)
			report_mismatch($sformatf("position %0d, expected %0d",
				got.position, want.position));
		if (got.final_item !== want.final_item)
			report_mismatch($sformatf("final_item %0b, expected %0b (pos %0d)",
				got.final_item, want.final_item, want.position));
	endtask

	// Monitor: samples both channels at the rising edge, feeds the predictor,
	// checks results and keeps the hang watchdog.
	always @(posedge clk) begin
		item_took = item_valid && item_ready;
		res_took  = result_valid && result_ready;
		if (item_took) begin
			words_taken++;
			absorb_word(item);
		end
		if (res_took)
			check_result(result);
		if (item_took || res_took)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d words still expected",
				HANG_LIMIT, match_exp.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Item driver: holds a word until it is taken, otherwise maybe idles.
	always @(negedge clk) begin
		if (!arst_n)
			item_valid <= 1'b0;
		else if (item_valid && !item_took)
			item_valid <= 1'b1;
		else if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			item       <= word_q.pop_front();
			item_valid <= 1'b1;
		end else
			item_valid <= 1'b0;
	end

	// Result receiver: random backpressure.
	always @(negedge clk)
		result_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);

	task automatic push_word(logic k, logic [BYTE_W-1:0] b, logic eot);
		word_q.insert(word_q.size(), '{kind: k, data_byte: b, end_of_text: eot});
		words_queued++;
	endtask

	// Block until the block has taken every word and sent every result.
	task automatic wait_quiet();
		while (words_taken != words_queued || match_exp.size() != 0)
			@(negedge clk);
	endtask

	// One random search: a pattern, a text ending in end_of_text, content drawn
	// from a tiny alphabet most of the time so matches are common. A few are
	// pure noise with random kind and stray end_of_text flags.
	task automatic add_search();
		int                r;
		int                plen;
		int                tlen;
		int                nsym;
		int                pi;
		int                ti;
		int                pos;
		bit                mixed;
		logic [BYTE_W-1:0] syms [4];
		logic [BYTE_W-1:0] pat [];
		logic [BYTE_W-1:0] txt [];

		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(8, 30))
				push_word(1'($urandom_range(1)), BYTE_W'($urandom_range(255)),
					$urandom_range(7) == 0);
			return;
		end

		r = $urandom_range(99);
		if (r < 5)
			plen = 0;
		else if (r < 85)
			plen = $urandom_range(1, 6);
		else if (r < 96)
			plen = $urandom_range(7, PAT_DEPTH);
		else
			plen = $urandom_range(PAT_DEPTH + 1, PAT_DEPTH + 4);   // store overflow

		r = $urandom_range(99);
		if (r < 10)
			tlen = $urandom_range(1, (plen > 1) ? plen : 1);      // often shorter than pattern
		else if (r < 93)
			tlen = $urandom_range((plen > 1) ? plen : 1, plen + 20);
		else
			tlen = $urandom_range(TXT_DEPTH - 4, TXT_DEPTH + 6);  // may overflow text

		r = $urandom_range(3);
		nsym = (r < 2) ? 2 : (r == 2) ? 4 : 0;
		foreach (syms[i])
			syms[i] = BYTE_W'($urandom_range(255));

		pat = new[plen];
		txt = new[tlen];
		foreach (pat[i])
			pat[i] = (nsym == 0) ? BYTE_W'($urandom_range(255))
			                     : syms[$urandom_range(nsym - 1)];
		foreach (txt[i])
			txt[i] = (nsym == 0) ? BYTE_W'($urandom_range(255))
			                     : syms[$urandom_range(nsym - 1)];

		// plant copies of the pattern so full-alphabet searches still hit
		if (plen > 0 && plen <= tlen && $urandom_range(2) != 0) begin
			repeat ($urandom_range(1, 3)) begin
				pos = $urandom_range(0, tlen - plen);
				for (int k = 0; k < plen; k++)
					txt[pos + k] = pat[k];
			end
		end

		// pattern and text words may interleave; all pattern words go ahead of
		// the closing text word
		mixed = ($urandom_range(99) < 15);
		pi = 0;
		ti = 0;
		while (pi < plen || ti < tlen - 1) begin
			if (pi < plen && (ti >= tlen - 1 || !mixed || $urandom_range(1) == 1)) begin
				push_word(KIND_PATTERN, pat[pi], $urandom_range(9) == 0);
				pi++;
			end else begin
				push_word(KIND_TEXT, txt[ti], 1'b0);
				ti++;
			end
		end
		push_word(KIND_TEXT, txt[tlen - 1], 1'b1);
	endtask

	initial begin
		int phase_start;

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		send_idle_pct = 18;
		recv_idle_pct = 84;

		// empty pattern: not-found
		push_word(KIND_TEXT, 8'h00, 1'b1);
		// single-byte pattern of all ones, matches at the start and at the very end
		push_word(KIND_PATTERN, 8'hFF, 1'b0);
		push_word(KIND_TEXT, 8'hFF, 1'b0);
		push_word(KIND_TEXT, 8'h00, 1'b0);
		push_word(KIND_TEXT, 8'hFF, 1'b1);
		// pattern longer than text: not-found
		push_word(KIND_PATTERN, 8'h01, 1'b0);
		push_word(KIND_PATTERN, 8'h02, 1'b0);
		push_word(KIND_PATTERN, 8'h03, 1'b0);
		push_word(KIND_TEXT, 8'h01, 1'b0);
		push_word(KIND_TEXT, 8'h02, 1'b1);
		// end_of_text on a pattern word must not start a search
		push_word(KIND_PATTERN, 8'hAA, 1'b1);
		push_word(KIND_PATTERN, 8'h55, 1'b0);
		push_word(KIND_TEXT, 8'hAA, 1'b0);
		push_word(KIND_TEXT, 8'h55, 1'b0);
		push_word(KIND_TEXT, 8'hAA, 1'b0);
		push_word(KIND_TEXT, 8'h55, 1'b1);
		// plain miss
		push_word(KIND_PATTERN, 8'h07, 1'b0);
		push_word(KIND_TEXT, 8'h08, 1'b0);
		push_word(KIND_TEXT, 8'h09, 1'b1);

		// sender holds off here until every match word is back
		wait_quiet();

		// three random phases: slow receiver, slow sender, then full speed
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 84 : 0;
			recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 18 : 0;
			phase_start = words_queued;
			while (words_queued - phase_start < 120)
				add_search();
			wait_quiet();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
